FILE: src/ncce_pkg.sv
// Shared constants and types for the notch cosine coefficient encoder.
`timescale 1ns / 1ps

package ncce_pkg;

    // Frequency limits in 1/16 Hz: half turn is 16 kHz, quarter turn is 8 kHz
    localparam int unsigned HALF_TURN_Q4    = 256000;
    localparam int unsigned QUARTER_TURN_Q4 = 128000;
    localparam int unsigned ROUND_Q4        = 256000;   // half of the full turn 512000

    // round(2*pi*2^32) = 512000 * PHASE_MUL_HI + PHASE_MUL_LO
    localparam int unsigned PHASE_MUL_HI = 52707;
    localparam int unsigned PHASE_MUL_LO = 91409;

    // floor(s / 125) = (s * DIV125_MUL) >> DIV125_SHIFT for s below 2^22
    localparam int unsigned DIV125_MUL   = 4294968;
    localparam int unsigned DIV125_SHIFT = 29;

    // CORDIC gain 0.6072529350088813 in Q32
    localparam longint GAIN_Q32 = 64'sd2608131496;

    // Coefficient limits
    localparam int unsigned DIRECT_LIMIT = 224;
    localparam int unsigned EDGE_LIMIT   = 255;

    // Side information that travels beside the datapath
    typedef struct packed {
        logic       dis;
        logic       neg;
        logic [2:0] bw;
    } side_t;

    // Arctangent of 2^-i in Q32 radians
    function automatic logic [31:0] atan_q32(input int i);
        logic [31:0] r;
        r = 32'd0;
        case (i)
            0:  r = 32'd3373259426;
            1:  r = 32'd1991351318;
            2:  r = 32'd1052175346;
            3:  r = 32'd534100635;
            4:  r = 32'd268086748;
            5:  r = 32'd134174063;
            6:  r = 32'd67103403;
            7:  r = 32'd33553749;
            8:  r = 32'd16777131;
            9:  r = 32'd8388597;
            10: r = 32'd4194303;
            default: r = 32'd1 << (32 - i);
        endcase
        return r;
    endfunction

endpackage

FILE: src/notch_cosine_coefficient_encoder.sv
// Top level: pipelined CORDIC cosine and notch coefficient encoding.
// Throughput: one word per cycle while the output is not stalled; one CORDIC iteration per pipeline stage.
// The whole pipeline advances while the output register is empty or being taken.
// Reset (aresetn low, synchronous) clears every stage valid bit and the output valid.
`timescale 1ns / 1ps

module notch_cosine_coefficient_encoder #(
    parameter int COS_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // center_freq_q4[18:0], bandwidth_code[21:19], zero pad
    input  logic [0:0]  s_tuser,   // notch_enable[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // coef_value[8:0], bandwidth_field[11:9], zero pad
    output logic [1:0]  m_tuser    // notch_disabled[0], coef_select[1]
);

    localparam int G    = COS_FRAC_BITS + 2;     // CORDIC fraction bits and iterations
    localparam int XW   = G + 3;                 // x and y width, signed
    localparam int ZW   = 35;                    // residual angle width, signed Q32
    localparam int MW   = COS_FRAC_BITS + 1;     // cosine magnitude 0 .. 1.0
    localparam int RW0  = MW + 9;
    localparam int RW1  = MW + 12;
    localparam longint X_INIT =
        (ncce_pkg::GAIN_Q32 + (64'sd1 <<< (31 - G))) >>> (32 - G);
    localparam logic [MW-1:0] ONE_C  = MW'(1) << COS_FRAC_BITS;
    localparam logic [RW1-1:0] HALF1 = RW1'(1) << (COS_FRAC_BITS - 1);
    localparam logic [RW0-1:0] HALF0 = RW0'(1) << (COS_FRAC_BITS - 1);

    logic adv;

    // Advance all stages when the output slot frees up
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 0: fold the frequency into the first quadrant
    logic [16:0]     p0_reg;
    ncce_pkg::side_t sd0_reg;
    logic            v0_reg;
    logic [18:0]     f_in;
    logic [17:0]     pc;
    logic [16:0]     p0_next;
    ncce_pkg::side_t sd0_next;

    assign f_in = s_tdata[18:0];

    always_comb begin
        pc = (f_in > 19'(ncce_pkg::HALF_TURN_Q4)) ? 18'(ncce_pkg::HALF_TURN_Q4) : f_in[17:0];
        sd0_next.dis = !s_tuser[0] || (f_in == 19'd0);
        sd0_next.bw  = s_tdata[21:19];
        if (pc > 18'(ncce_pkg::QUARTER_TURN_Q4)) begin
            p0_next      = 17'(18'(ncce_pkg::HALF_TURN_Q4) - pc);
            sd0_next.neg = 1'b1;
        end else begin
            p0_next      = pc[16:0];
            sd0_next.neg = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
        if (adv) begin
            p0_reg  <= p0_next;
            sd0_reg <= sd0_next;
        end
    end

    // Stage 1: split the phase product into whole and remainder parts
    logic [32:0]     pa1_reg;
    logic [33:0]     rb1_reg;
    ncce_pkg::side_t sd1_reg;
    logic            v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
        if (adv) begin
            pa1_reg <= 33'({16'd0, p0_reg} * 33'(ncce_pkg::PHASE_MUL_HI));
            rb1_reg <= 34'({17'd0, p0_reg} * 34'(ncce_pkg::PHASE_MUL_LO))
                       + 34'(ncce_pkg::ROUND_Q4);
            sd1_reg <= sd0_reg;
        end
    end

    // Stage 2: divide the remainder by 512000 as a shift and a reciprocal multiply
    logic [32:0]     pa2_reg;
    logic [14:0]     q2_reg;
    ncce_pkg::side_t sd2_reg;
    logic            v2_reg;
    logic [21:0]     rs;
    logic [44:0]     qprod;

    assign rs    = rb1_reg[33:12];
    assign qprod = {23'd0, rs} * 45'(ncce_pkg::DIV125_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            pa2_reg <= pa1_reg;
            q2_reg  <= qprod[ncce_pkg::DIV125_SHIFT +: 15];
            sd2_reg <= sd1_reg;
        end
    end

    // Stage 3 and CORDIC: angle load, then one rotation per stage
    logic signed [XW-1:0] x_reg [0:G];
    logic signed [XW-1:0] y_reg [0:G];
    logic signed [ZW-1:0] z_reg [0:G];
    ncce_pkg::side_t      sdc_reg [0:G];
    logic                 vc_reg [0:G];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg[0] <= 1'b0;
        end else if (adv) begin
            vc_reg[0] <= v2_reg;
        end
        if (adv) begin
            x_reg[0]   <= XW'(X_INIT);
            y_reg[0]   <= '0;
            z_reg[0]   <= $signed(ZW'(pa2_reg) + ZW'(q2_reg));
            sdc_reg[0] <= sd2_reg;
        end
    end

    for (genvar i = 0; i < G; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN_I = $signed(ZW'(ncce_pkg::atan_q32(i)));
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        // Rotate toward zero residual angle
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vc_reg[i+1] <= 1'b0;
            end else if (adv) begin
                vc_reg[i+1] <= vc_reg[i];
            end
            if (adv) begin
                sdc_reg[i+1] <= sdc_reg[i];
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
            end
        end
    end

    // Post stage: round the cosine to COS_FRAC_BITS and clamp to 0 .. 1.0
    logic [MW-1:0]        mag_reg;
    ncce_pkg::side_t      sdm_reg;
    logic                 vm_reg;
    logic signed [XW-1:0] xr;
    logic [MW-1:0]        mag_next;

    always_comb begin
        xr = (x_reg[G] + XW'(2)) >>> 2;
        if (xr[XW-1]) begin
            mag_next = '0;
        end else if (xr > $signed(XW'(ONE_C))) begin
            mag_next = ONE_C;
        end else begin
            mag_next = xr[MW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (adv) begin
            vm_reg <= vc_reg[G];
        end
        if (adv) begin
            mag_reg <= mag_next;
            sdm_reg <= sdc_reg[G];
        end
    end

    // Output stage: pick the coefficient form, round, clamp and sign
    logic           sel;
    logic [RW0-1:0] r0;
    logic [RW1-1:0] r1;
    logic [MW-1:0]  dmag;
    logic [8:0]     v0m;
    logic [8:0]     v1m;
    logic [8:0]     vmag;
    logic [8:0]     coef;
    logic           m_valid_reg;
    logic [15:0]    m_data_reg;
    logic [1:0]     m_user_reg;

    always_comb begin
        sel  = ({3'd0, mag_reg, 3'd0} > (MW + 6)'(7) << COS_FRAC_BITS);
        r0   = (RW0'({mag_reg, 8'd0}) + HALF0) >> COS_FRAC_BITS;
        v0m  = (r0 > RW0'(ncce_pkg::DIRECT_LIMIT)) ? 9'(ncce_pkg::DIRECT_LIMIT) : r0[8:0];
        dmag = ONE_C - mag_reg;
        r1   = (RW1'({dmag, 11'd0}) + HALF1) >> COS_FRAC_BITS;
        if (r1 == '0) begin
            v1m = 9'd1;
        end else if (r1 > RW1'(ncce_pkg::EDGE_LIMIT)) begin
            v1m = 9'(ncce_pkg::EDGE_LIMIT);
        end else begin
            v1m = r1[8:0];
        end
        vmag = sel ? v1m : v0m;
        coef = sdm_reg.neg ? 9'(-vmag) : vmag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vm_reg;
        end
        if (adv) begin
            if (sdm_reg.dis) begin
                m_data_reg <= '0;
                m_user_reg <= 2'b01;
            end else begin
                m_data_reg <= {4'd0, sdm_reg.bw, coef};
                m_user_reg <= {sel, 1'b0};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // A disabled notch carries no coefficient, select or bandwidth
    a_dis_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0 && !m_tuser[1])
        else $error("disabled word carries nonzero fields");

    // The near-edge form never yields a zero coefficient
    a_edge_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[8:0] != 9'd0)
        else $error("near-edge coefficient is zero");

    // The direct form stays within the direct clamp
    a_direct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |->
            $signed(m_tdata[8:0]) <= 224 && $signed(m_tdata[8:0]) >= -224)
        else $error("direct coefficient out of range");

    // A word leaving the CORDIC reaches the rounding stage on the next advance
    a_cordic_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        vc_reg[G] && adv |=> vm_reg)
        else $error("word lost between CORDIC and rounding stage");

endmodule

FILE: tb/sv/tb_notch_cosine_coefficient_encoder.sv
// Self-checking testbench for the notch cosine coefficient encoder stream block.
`timescale 1ns / 1ps

module tb_notch_cosine_coefficient_encoder;

    localparam int COS_FRAC       = 16;
    localparam int CORDIC_STEPS   = COS_FRAC + 2;
    localparam int RANDOM_WORDS   = 1750;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES    = 300;
    localparam int BURST_FIRST    = 250;
    localparam int BURST_LAST     = 700;

    // Frequency points in 1/16 Hz
    localparam longint HALF_TURN    = 256000;
    localparam longint QUARTER_TURN = 128000;
    localparam longint FULL_TURN    = 512000;
    localparam longint EDGE_POINT   = 41181;    // where cos crosses 0.875
    localparam longint TWO_PI_Q32   = 64'sd26986075409;
    localparam longint CORDIC_GAIN  = 64'sd2608131496;
    localparam int     DIRECT_MAX   = 224;
    localparam int     EDGE_MAX     = 255;

    localparam longint ARCTAN_Q32 [0:10] = '{
        64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
        64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
        64'sd16777131, 64'sd8388597, 64'sd4194303
    };

    typedef struct packed {
        logic              disabled;
        logic signed [8:0] coef;
        logic              select;
        logic [2:0]        bw;
    } notch_coef_t;

    typedef struct packed {
        logic        en;
        logic [18:0] freq;
        logic [2:0]  bw;
        logic        typed;     // 1: use the coefficient written in the row
        notch_coef_t want;
    } notch_row_t;

    localparam int ROW_COUNT = 22;
    localparam notch_row_t DIRECTED_ROWS [0:ROW_COUNT-1] = '{
        // disabled notch and zero frequency
        '{1'b0, 19'd1000,   3'd5, 1'b1, '{1'b1, 9'sd0, 1'b0, 3'd0}},
        '{1'b1, 19'd0,      3'd7, 1'b1, '{1'b1, 9'sd0, 1'b0, 3'd0}},
        '{1'b0, 19'd524287, 3'd7, 1'b1, '{1'b1, 9'sd0, 1'b0, 3'd0}},
        '{1'b0, 19'd0,      3'd0, 1'b1, '{1'b1, 9'sd0, 1'b0, 3'd0}},
        // lowest frequency: cos near one, zero coefficient forced to plus one
        '{1'b1, 19'd1,      3'd0, 1'b1, '{1'b0, 9'sd1, 1'b1, 3'd0}},
        // angle at or above pi: cos of minus one, forced to minus one
        '{1'b1, 19'd256000, 3'd1, 1'b1, '{1'b0, -9'sd1, 1'b1, 3'd1}},
        '{1'b1, 19'd524287, 3'd2, 1'b1, '{1'b0, -9'sd1, 1'b1, 3'd2}},
        '{1'b1, 19'd256001, 3'd3, 1'b1, '{1'b0, -9'sd1, 1'b1, 3'd3}},
        '{1'b1, 19'd262144, 3'd7, 1'b1, '{1'b0, -9'sd1, 1'b1, 3'd7}},
        // quarter turn: cos of zero
        '{1'b1, 19'd128000, 3'd4, 1'b1, '{1'b0, 9'sd0, 1'b0, 3'd4}},
        // entry into the second quadrant
        '{1'b1, 19'd128001, 3'd5, 1'b0, '0},
        '{1'b1, 19'd127999, 3'd6, 1'b0, '0},
        // around the 0.875 switch point and its mirror
        '{1'b1, 19'd41170,  3'd1, 1'b0, '0},
        '{1'b1, 19'd41180,  3'd2, 1'b0, '0},
        '{1'b1, 19'd41181,  3'd3, 1'b0, '0},
        '{1'b1, 19'd41182,  3'd4, 1'b0, '0},
        '{1'b1, 19'd41190,  3'd5, 1'b0, '0},
        '{1'b1, 19'd214819, 3'd6, 1'b0, '0},
        '{1'b1, 19'd214830, 3'd7, 1'b0, '0},
        // assorted mid-band points
        '{1'b1, 19'd85333,  3'd0, 1'b0, '0},
        '{1'b1, 19'd16000,  3'd1, 1'b0, '0},
        '{1'b1, 19'd200000, 3'd2, 1'b0, '0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;     // center_freq_q4[18:0], bandwidth_code[21:19], zero pad
    logic [0:0]  s_tuser  = '0;     // notch_enable[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // coef_value[8:0], bandwidth_field[11:9], zero pad
    logic [1:0]  m_tuser;           // notch_disabled[0], coef_select[1]

    notch_coef_t pending_coefs [$];
    int          mismatches   = 0;
    int          words_sent   = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;

    notch_cosine_coefficient_encoder #(
        .COS_FRAC_BITS(COS_FRAC)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Generate the 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Compute the expected coefficient word for one request
    function automatic notch_coef_t encode_notch(input logic en, input logic [18:0] freq,
                                                 input logic [2:0] bw);
        notch_coef_t r;
        longint      phase, theta, x, y, z, dx, dy, step_angle, mag, val, unity, half;
        logic        neg;
        int          i;
        r     = '0;
        unity = 64'sd1 <<< COS_FRAC;
        half  = 64'sd1 <<< (COS_FRAC - 1);
        if (!en || freq == 19'd0) begin
            r.disabled = 1'b1;
            return r;
        end
        // fold the phase into the first quadrant
        phase = (longint'(freq) > HALF_TURN) ? HALF_TURN : longint'(freq);
        neg   = 1'b0;
        if (phase > QUARTER_TURN) begin
            phase = HALF_TURN - phase;
            neg   = 1'b1;
        end
        theta = (phase * TWO_PI_Q32 + FULL_TURN / 2) / FULL_TURN;
        // rotation-mode CORDIC from the gain-compensated start vector
        x = (CORDIC_GAIN + (64'sd1 <<< (31 - CORDIC_STEPS))) >>> (32 - CORDIC_STEPS);
        y = 0;
        z = theta;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx         = y >>> i;
            dy         = x >>> i;
            step_angle = (i < 11) ? ARCTAN_Q32[i] : (64'sd1 <<< (32 - i));
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - step_angle;
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + step_angle;
            end
        end
        mag = (x + 2) >>> 2;
        if (mag < 0)
            mag = 0;
        if (mag > unity)
            mag = unity;
        // direct form at or below 0.875, scaled distance from the edge above it
        if (mag * 8 <= 7 * unity) begin
            r.select = 1'b0;
            val = (mag * 256 + half) >>> COS_FRAC;
            if (val > DIRECT_MAX)
                val = DIRECT_MAX;
            if (neg)
                val = -val;
        end else begin
            r.select = 1'b1;
            val = ((unity - mag) * 2048 + half) >>> COS_FRAC;
            if (neg)
                val = -val;
            if (val == 0)
                val = neg ? -1 : 1;
            if (val > EDGE_MAX)
                val = EDGE_MAX;
            if (val < -EDGE_MAX)
                val = -EDGE_MAX;
        end
        r.coef = val[8:0];
        r.bw   = bw;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: %s expected %0d, got %0d",
                     results_seen, field, want, got);
    endtask

    // Send one request word and hold it until it is taken
    task automatic send_request(input logic en, input logic [18:0] freq, input logic [2:0] bw,
                                input logic typed, input notch_coef_t want, input int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, bw, freq};
        s_tuser  <= en;
        do
            @(posedge aclk);
        while (!s_tready);
        pending_coefs.push_back(typed ? want : encode_notch(en, freq, bw));
        words_sent++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [18:0] draw_frequency();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return 19'($urandom_range(0, 524287));
        if (pick < 70)
            return 19'($urandom_range(1, 256000));
        if (pick < 80)
            return 19'($urandom_range(32'(EDGE_POINT - 64), 32'(EDGE_POINT + 64)));
        if (pick < 88)
            return 19'($urandom_range(32'(HALF_TURN - EDGE_POINT - 64),
                                      32'(HALF_TURN - EDGE_POINT + 64)));
        if (pick < 94)
            return 19'($urandom_range(32'(QUARTER_TURN - 64), 32'(QUARTER_TURN + 64)));
        return 19'($urandom_range(0, 16));
    endfunction

    // Take result words with random stalls and check them in order
    initial begin : result_side
        notch_coef_t want, got;
        int          wait_cycles;
        @(posedge aclk iff aresetn);
        forever begin
            if (results_seen == HOLD_AT_RESULT)
                wait_cycles = HOLD_CYCLES;
            else if (results_seen % 160 < 40)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, 14);
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
            do
                @(posedge aclk);
            while (!(m_tvalid && m_tready));
            got.disabled = m_tuser[0];
            got.select   = m_tuser[1];
            got.coef     = m_tdata[8:0];
            got.bw       = m_tdata[11:9];
            if (pending_coefs.size() == 0) begin
                note_mismatch("unexpected word, coef_value", 0, int'(got.coef));
            end else begin
                want = pending_coefs.pop_front();
                if (got.disabled !== want.disabled)
                    note_mismatch("notch_disabled", want.disabled, got.disabled);
                if (got.coef !== want.coef)
                    note_mismatch("coef_value", int'(want.coef), int'(got.coef));
                if (got.select !== want.select)
                    note_mismatch("coef_select", want.select, got.select);
                if (got.bw !== want.bw)
                    note_mismatch("bandwidth_field", want.bw, got.bw);
            end
            results_seen++;
        end
    end

    // Reset, directed table, random requests, drain
    initial begin : request_side
        int          n, gap;
        logic        en;
        logic [18:0] freq;
        logic [2:0]  bw;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (n = 0; n < ROW_COUNT; n++) begin
            gap = (n < ROW_COUNT / 2) ? 0 : $urandom_range(0, 14);
            send_request(DIRECTED_ROWS[n].en, DIRECTED_ROWS[n].freq, DIRECTED_ROWS[n].bw,
                         DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want, gap);
        end

        for (n = 0; n < RANDOM_WORDS; n++) begin
            en   = ($urandom_range(0, 9) != 0);
            freq = draw_frequency();
            bw   = 3'($urandom_range(0, 7));
            // back-to-back stretches, plus a long burst against the output hold-off
            if ((n >= BURST_FIRST && n < BURST_LAST) || (n % 128 < 32))
                gap = 0;
            else
                gap = $urandom_range(0, 14);
            send_request(en, freq, bw, 1'b0, '0, gap);
        end
        s_tvalid <= 1'b0;

        while (pending_coefs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_coefs.size() == 0 && results_seen == words_sent) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
